@@ hw/rtl/track_dwell_event_table_assert.svh @@
// Assertion macros for the track dwell event table
`ifndef TRACK_DWELL_EVENT_TABLE_ASSERT_SVH
`define TRACK_DWELL_EVENT_TABLE_ASSERT_SVH

// same-cycle implication
`define TDET_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tdet assertion failed");

// next-cycle implication
`define TDET_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tdet assertion failed");

`endif

@@ hw/rtl/tdet_pkg.sv @@
// Shared types and constants for the track dwell event table
`default_nettype none
package tdet_pkg;
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [2:0] KIND_IGNORED    = 3'd0;
  localparam logic [2:0] KIND_TRACKED    = 3'd1;
  localparam logic [2:0] KIND_ENTERED    = 3'd2;
  localparam logic [2:0] KIND_EXITED     = 3'd3;
  localparam logic [2:0] KIND_FRAME_DONE = 3'd4;
  localparam logic [2:0] KIND_TABLE_FULL = 3'd5;

  localparam logic [7:0] REG_ENTRY_MIN     = 8'd0;
  localparam logic [7:0] REG_EXIT_TIMEOUT  = 8'd1;
  localparam logic [7:0] REG_MIN_EXIT_DWELL = 8'd2;

  typedef struct packed {
    logic        op;
    logic        ignored;
    logic [15:0] det_id;
    logic [31:0] time_ms;
  } item_t;

  typedef struct packed {
    logic [31:0] entry_min_ms;
    logic [31:0] exit_timeout_ms;
    logic [31:0] min_exit_dwell_ms;
  } cfg_t;
endpackage
`default_nettype wire

@@ hw/rtl/tdet_front.sv @@
// Front end: accepts input words, classifies them and queues them
`default_nettype none
module tdet_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire logic [47:0]    s_tdata,  // det_id[15:0], time_ms[47:16]
  input  wire logic [1:0]     s_tuser,  // operation[0], is_person[1]
  output logic                q_valid,
  input  wire logic           q_ready,
  output tdet_pkg::item_t     q_item
);
  tdet_pkg::item_t buf_q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  tdet_pkg::item_t in_item;

  always_comb begin
    in_item.op       = s_tuser[0];
    in_item.det_id   = s_tdata[15:0];
    in_item.time_ms  = s_tdata[47:16];
    in_item.ignored  = !s_tuser[1] || s_tdata[15];
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = buf_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        buf_q[wr_ptr] <= in_item;
        wr_ptr        <= !wr_ptr;
      end
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/tdet_back.sv @@
// Back end: track table, id match, update and frame-end sweep
`default_nettype none
module tdet_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire tdet_pkg::cfg_t cfg,
  input  wire logic           q_valid,
  output logic                q_ready,
  input  wire tdet_pkg::item_t q_item,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic [47:0]         m_tdata,  // track_id_out[15:0], dwell_ms[47:16]
  output logic [2:0]          m_tuser,  // kind[2:0]
  output logic                m_tlast
);
  localparam int D = tdet_pkg::TABLE_DEPTH;
  localparam int W = tdet_pkg::IDX_W;

  typedef enum logic [2:0] {
    S_IDLE, S_MATCH, S_UPDATE, S_ENTER, S_SWEEP, S_LASTOUT
  } state_t;

  state_t state;
  logic [D-1:0] valid;
  logic [D-1:0] seen;
  logic [D-1:0] entered;
  logic [D-1:0] exited;
  logic [D-1:0] visible;
  logic [15:0]  tid      [D];
  logic [31:0]  first_ms [D];
  logic [31:0]  last_ms  [D];

  tdet_pkg::item_t cur;
  logic [W-1:0] idx;
  logic [31:0]  dwell_r;
  logic [2:0]   res_kind;
  logic [15:0]  res_id;

  logic [2:0]   out_kind;
  logic [15:0]  out_id;
  logic [31:0]  out_dwell;

  logic         hit_found;
  logic [W-1:0] hit_idx;
  logic         free_found;
  logic [W-1:0] free_idx;
  logic         out_free;
  logic         out_load;
  logic [31:0]  upd_dwell;
  logic         fire;
  logic [31:0]  sw_dwell;
  logic [31:0]  sw_unseen;
  logic         sw_exit;

  always_comb begin
    hit_found  = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = D - 1; i >= 0; i--) begin
      if (valid[i] && tid[i] == cur.det_id) begin
        hit_found = 1'b1;
        hit_idx   = W'(i);
      end
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx   = W'(i);
      end
    end
  end

  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = out_free && ((state == S_UPDATE) || (state == S_ENTER) ||
                                  (state == S_LASTOUT) || (state == S_SWEEP && sw_exit));
  assign upd_dwell = cur.time_ms - first_ms[idx];
  assign fire      = !entered[idx] && (upd_dwell >= cfg.entry_min_ms);
  assign sw_dwell  = last_ms[idx] - first_ms[idx];
  assign sw_unseen = cur.time_ms - last_ms[idx];
  assign sw_exit   = valid[idx] && !seen[idx] && visible[idx] && !exited[idx] &&
                     (sw_unseen >= cfg.exit_timeout_ms) &&
                     (sw_dwell >= cfg.min_exit_dwell_ms);
  assign q_ready   = (state == S_IDLE);
  assign m_tdata   = {out_dwell, out_id};
  assign m_tuser   = out_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      valid    <= '0;
      seen     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            idx <= '0;
            if (q_item.op) begin
              state <= S_SWEEP;
            end else if (q_item.ignored) begin
              res_kind <= tdet_pkg::KIND_IGNORED;
              res_id   <= q_item.det_id;
              state    <= S_LASTOUT;
            end else begin
              state <= S_MATCH;
            end
          end
        end
        S_MATCH: begin
          res_id <= cur.det_id;
          if (hit_found) begin
            idx   <= hit_idx;
            state <= S_UPDATE;
          end else if (free_found) begin
            valid[free_idx]    <= 1'b1;
            tid[free_idx]      <= cur.det_id;
            first_ms[free_idx] <= cur.time_ms;
            last_ms[free_idx]  <= cur.time_ms;
            entered[free_idx]  <= 1'b0;
            exited[free_idx]   <= 1'b0;
            visible[free_idx]  <= 1'b1;
            seen[free_idx]     <= 1'b1;
            res_kind           <= tdet_pkg::KIND_TRACKED;
            state              <= S_LASTOUT;
          end else begin
            res_kind <= tdet_pkg::KIND_TABLE_FULL;
            state    <= S_LASTOUT;
          end
        end
        S_UPDATE: begin
          if (out_free) begin
            out_kind     <= tdet_pkg::KIND_TRACKED;
            out_id       <= cur.det_id;
            out_dwell    <= upd_dwell;
            m_tlast      <= !fire;
            last_ms[idx] <= cur.time_ms;
            visible[idx] <= 1'b1;
            exited[idx]  <= 1'b0;
            seen[idx]    <= 1'b1;
            dwell_r      <= upd_dwell;
            if (fire) begin
              entered[idx] <= 1'b1;
              state        <= S_ENTER;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_ENTER: begin
          if (out_free) begin
            out_kind  <= tdet_pkg::KIND_ENTERED;
            out_id    <= cur.det_id;
            out_dwell <= dwell_r;
            m_tlast   <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_SWEEP: begin
          if (!sw_exit || out_free) begin
            if (sw_exit) begin
              out_kind     <= tdet_pkg::KIND_EXITED;
              out_id       <= tid[idx];
              out_dwell    <= sw_dwell;
              m_tlast      <= 1'b0;
              visible[idx] <= 1'b0;
              exited[idx]  <= 1'b1;
            end
            seen[idx] <= 1'b0;
            if (idx == W'(D - 1)) begin
              res_kind <= tdet_pkg::KIND_FRAME_DONE;
              res_id   <= '0;
              state    <= S_LASTOUT;
            end else begin
              idx <= idx + W'(1);
            end
          end
        end
        S_LASTOUT: begin
          if (out_free) begin
            out_kind  <= res_kind;
            out_id    <= res_id;
            out_dwell <= '0;
            m_tlast   <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/track_dwell_event_table.sv @@
// Top level of the track dwell event table
// Keeps one entry per tracked person and reports dwell, entered and exited
// events. Input words land in a two-word queue, so the upstream side keeps
// moving while results stall, until it fills. A known-track detection goes
// through dequeue, parallel id match and update in the back end, plus an
// entered event when one follows; a new-track or table-full word through
// dequeue, match and result, an ignored word through dequeue and result. A
// frame-end word runs the sweep, one table entry per cycle unless an exited
// event waits, then a frame-done result. A stalled consumer holds the back
// end. The config port is always ready; write it only while the block is idle.
`default_nettype none
module track_dwell_event_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // det_id[15:0], time_ms[47:16]
  input  wire logic [1:0]  s_tuser,  // operation[0], is_person[1]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,  // track_id_out[15:0], dwell_ms[47:16]
  output logic [2:0]       m_tuser,  // kind[2:0]
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  tdet_pkg::cfg_t  cfg;
  tdet_pkg::item_t q_item;
  logic            q_valid;
  logic            q_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.entry_min_ms      <= 32'd500;
      cfg.exit_timeout_ms   <= 32'd1000;
      cfg.min_exit_dwell_ms <= 32'd1000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tdet_pkg::REG_ENTRY_MIN:      cfg.entry_min_ms      <= cfg_data;
        tdet_pkg::REG_EXIT_TIMEOUT:   cfg.exit_timeout_ms   <= cfg_data;
        tdet_pkg::REG_MIN_EXIT_DWELL: cfg.min_exit_dwell_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  tdet_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  tdet_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  `include "track_dwell_event_table_assert.svh"

  `TDET_ASSERT_NOW(a_done_last, m_tvalid && m_tuser == tdet_pkg::KIND_FRAME_DONE, m_tlast)
  `TDET_ASSERT_NOW(a_enter_last, m_tvalid && m_tuser == tdet_pkg::KIND_ENTERED, m_tlast)
  `TDET_ASSERT_NOW(a_exit_not_last, m_tvalid && m_tuser == tdet_pkg::KIND_EXITED, !m_tlast)
  `TDET_ASSERT_NEXT(a_enter_after_tracked,
    m_tvalid && m_tready && m_tuser == tdet_pkg::KIND_TRACKED && !m_tlast,
    !(m_tvalid && m_tuser != tdet_pkg::KIND_ENTERED))
endmodule
`default_nettype wire
